FILE: hw/rtl/hra_pkg.sv
// ----------------------------------------------------------------------------
// hra_pkg: shared types and constants of the hourly running average
// Word layouts, register map, status and encoding codes, and fixed widths.
// ----------------------------------------------------------------------------
package hra_pkg;

    localparam int SAMPLE_W    = 48;
    localparam int MINUTE_W    = 6;
    localparam int STATUS_W    = 2;
    localparam int KIND_W      = 2;
    localparam int AVG_HOURS_W = 6;
    localparam int FRAC_W      = 16;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    // Sums of up to 257 Q32.16 values need 57 signed bits.
    localparam int SUM_W       = 57;

    localparam logic [MINUTE_W-1:0] LAST_MINUTE = 6'd59;
    localparam logic [SAMPLE_W-1:0] Q_MAX       = 48'h7FFF_FFFF_FFFF;

    localparam logic [STATUS_W-1:0] STATUS_NO_CHANGE = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NEW_VALUE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_UNSIGNED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIXED    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SIGNED   = 2'd2;

    localparam logic [1:0] REG_AVG_HOURS   = 2'd0;
    localparam logic [1:0] REG_SOURCE_KIND = 2'd1;
    localparam logic [1:0] REG_RESULT_KIND = 2'd2;

    localparam logic [AVG_HOURS_W-1:0] AVG_HOURS_RESET = 6'd1;

    typedef struct packed {
        logic [MINUTE_W-1:0]        minute;
        logic                       sample_good;
        logic signed [SAMPLE_W-1:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [SAMPLE_W-1:0] average;
    } out_word_t;

    typedef struct packed {
        logic [AVG_HOURS_W-1:0] avg_hours;
        logic [KIND_W-1:0]      source_kind;
        logic [KIND_W-1:0]      result_kind;
    } cfg_t;

endpackage

FILE: hw/rtl/hourly_running_average.sv
// ----------------------------------------------------------------------------
// hourly_running_average: two-level moving average of polled minute samples
// A word with a repeated minute, a bad sample or a bad encoding (the last only
// while a minute slot is free) is answered from the evaluation step. Any other
// word passes through the shared divider twice (each pass: start, 29 steps,
// finish; the first is skipped while no minute is counted), and a commit at
// minute 59 adds a commit step plus a read and a subtract step per dropped entry.
// Reset is synchronous; no clearing pass runs, the block is ready at once.
// ----------------------------------------------------------------------------
module hourly_running_average #(
    parameter int MINUTE_SLOTS = 64,
    parameter int HOUR_SLOTS   = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // Input word channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  hra_pkg::in_word_t          s_word,
    // Result word channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output hra_pkg::out_word_t         m_word,
    // Configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hra_pkg::ADDR_W-1:0] paddr,
    input  logic [hra_pkg::DATA_W-1:0] pwdata,
    output logic [hra_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import hra_pkg::*;

    // Counter widths follow from the slot counts. The divisor is either the
    // minute count or the hour count plus one, so it must hold the larger.
    localparam int MC_W    = $clog2(MINUTE_SLOTS + 1);
    localparam int HC_W    = $clog2(HOUR_SLOTS + 1);
    localparam int HI_W    = (HOUR_SLOTS > 1) ? $clog2(HOUR_SLOTS) : 1;
    localparam int DIV_MAX = (MINUTE_SLOTS > HOUR_SLOTS + 1) ? MINUTE_SLOTS : HOUR_SLOTS + 1;
    localparam int DIVW    = $clog2(DIV_MAX + 1);
    localparam int CMP_W   = (HC_W > AVG_HOURS_W) ? HC_W : AVG_HOURS_W;

    // The sequencer walks one word through these steps.
    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_EVAL    = 10'b00_0000_0010,
        ST_HSTART  = 10'b00_0000_0100,
        ST_HWAIT   = 10'b00_0000_1000,
        ST_OSTART  = 10'b00_0001_0000,
        ST_OWAIT   = 10'b00_0010_0000,
        ST_DROP    = 10'b00_0100_0000,
        ST_DROPSUB = 10'b00_1000_0000,
        ST_SHOW    = 10'b01_0000_0000,
        ST_OUT     = 10'b10_0000_0000
    } state_t;

    state_t                     state_reg, state_next;
    in_word_t                   item_reg;
    logic [MINUTE_W-1:0]        seen_minute_reg, seen_minute_next;
    logic [MC_W-1:0]            minute_count_reg, minute_count_next;
    logic signed [SUM_W-1:0]    minute_sum_reg, minute_sum_next;
    logic [HC_W-1:0]            hour_count_reg, hour_count_next;
    logic [HI_W-1:0]            hour_head_reg, hour_head_next;
    logic signed [SUM_W-1:0]    hour_sum_reg, hour_sum_next;
    logic signed [SAMPLE_W-1:0] hour_avg_reg, hour_avg_next;
    logic signed [SAMPLE_W-1:0] overall_reg, overall_next;
    logic signed [SAMPLE_W-1:0] shown_value_reg, shown_value_next;
    out_word_t                  res_reg, res_next;
    logic                       m_valid_reg;
    out_word_t                  m_word_reg;

    cfg_t                       cfg;

    // Shared divider
    logic                       div_start;
    logic signed [SUM_W-1:0]    div_dividend;
    logic [DIVW-1:0]            div_divisor;
    logic                       div_busy;
    logic                       div_done;
    logic signed [SUM_W-1:0]    div_quotient;

    // Window storage
    logic                       win_we;
    logic [HI_W-1:0]            win_waddr;
    logic signed [SAMPLE_W-1:0] win_rdata;

    // Helpers
    logic [31:0]                sample_lo;
    logic signed [SAMPLE_W-1:0] sample_q;
    logic                       sample_bad;
    logic [CMP_W-1:0]           ah_ext;
    logic [HC_W-1:0]            eff_hours;
    logic [HC_W:0]              wr_sum;
    logic signed [SAMPLE_W-1:0] trunc_val;
    logic signed [SAMPLE_W-1:0] shown_cand;
    logic                       cand_ok;
    logic                       out_load;

    hra_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hra_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (DIVW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    hra_window #(
        .DEPTH  (HOUR_SLOTS),
        .ADDR_W (HI_W)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (win_we),
        .wr_addr (win_waddr),
        .wr_data (hour_avg_reg),
        .rd_addr (hour_head_reg),
        .rd_data (win_rdata)
    );

    // Sample decoding. Unsigned integers saturate at the largest Q32.16
    // value; signed integers simply move up by sixteen bits.
    always_comb begin
        sample_lo  = item_reg.sample[31:0];
        sample_bad = 1'b0;
        case (cfg.source_kind)
            KIND_UNSIGNED: sample_q = sample_lo[31] ? Q_MAX : {sample_lo, 16'h0000};
            KIND_FIXED:    sample_q = item_reg.sample;
            KIND_SIGNED:   sample_q = {sample_lo, 16'h0000};
            default: begin
                sample_q   = '0;
                sample_bad = 1'b1;
            end
        endcase
    end

    // The window length register is clamped into one to HOUR_SLOTS.
    always_comb begin
        ah_ext = CMP_W'(cfg.avg_hours);
        if (ah_ext == '0) begin
            eff_hours = HC_W'(1);
        end else if (ah_ext > CMP_W'(HOUR_SLOTS)) begin
            eff_hours = HC_W'(HOUR_SLOTS);
        end else begin
            eff_hours = ah_ext[HC_W-1:0];
        end
    end

    // The new entry goes just past the newest one, wrapping around the ring.
    always_comb begin
        wr_sum = (HC_W+1)'(hour_head_reg) + (HC_W+1)'(hour_count_reg);
        if (wr_sum >= (HC_W+1)'(HOUR_SLOTS)) begin
            wr_sum = wr_sum - (HC_W+1)'(HOUR_SLOTS);
        end
        win_waddr = wr_sum[HI_W-1:0];
    end

    // Integer result forms drop the fraction toward zero: a negative value
    // with any fraction bits set moves up to the next whole number.
    assign trunc_val = {overall_reg[SAMPLE_W-1:FRAC_W], {FRAC_W{1'b0}}}
                     + ((overall_reg[SAMPLE_W-1] && (overall_reg[FRAC_W-1:0] != '0))
                        ? SAMPLE_W'(1 << FRAC_W) : '0);

    // The divider is shared: the hour average first, then the overall one.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = minute_sum_reg;
        div_divisor  = DIVW'(minute_count_reg);
        if (state_reg == ST_HSTART) begin
            div_start = (minute_count_reg != '0);
        end else if (state_reg == ST_OSTART) begin
            div_start    = 1'b1;
            div_dividend = hour_sum_reg + {{(SUM_W-SAMPLE_W){hour_avg_reg[SAMPLE_W-1]}},
                                           hour_avg_reg};
            div_divisor  = DIVW'(hour_count_reg) + DIVW'(1);
        end
    end

    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // Main sequencer.
    always_comb begin
        state_next        = state_reg;
        seen_minute_next  = seen_minute_reg;
        minute_count_next = minute_count_reg;
        minute_sum_next   = minute_sum_reg;
        hour_count_next   = hour_count_reg;
        hour_head_next    = hour_head_reg;
        hour_sum_next     = hour_sum_reg;
        hour_avg_next     = hour_avg_reg;
        overall_next      = overall_reg;
        shown_value_next  = shown_value_reg;
        res_next          = res_reg;
        win_we            = 1'b0;
        shown_cand        = overall_reg;
        cand_ok           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EVAL;
                end
            end

            ST_EVAL: begin
                if (item_reg.minute == seen_minute_reg) begin
                    // A repeated minute leaves everything as it is.
                    res_next   = '{status: STATUS_NO_CHANGE, average: shown_value_reg};
                    state_next = ST_OUT;
                end else if (!item_reg.sample_good) begin
                    seen_minute_next = item_reg.minute;
                    res_next         = '{status: STATUS_ERROR, average: '0};
                    state_next       = ST_OUT;
                end else if (minute_count_reg < MC_W'(MINUTE_SLOTS)) begin
                    seen_minute_next = item_reg.minute;
                    if (sample_bad) begin
                        res_next   = '{status: STATUS_ERROR, average: '0};
                        state_next = ST_OUT;
                    end else begin
                        minute_sum_next   = minute_sum_reg
                                          + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
                        minute_count_next = minute_count_reg + 1'b1;
                        state_next        = ST_HSTART;
                    end
                end else begin
                    // All minute slots are taken, so the sample is not read.
                    seen_minute_next = item_reg.minute;
                    state_next       = ST_HSTART;
                end
            end

            ST_HSTART: begin
                if (minute_count_reg == '0) begin
                    hour_avg_next = '0;
                    state_next    = ST_OSTART;
                end else begin
                    state_next = ST_HWAIT;
                end
            end

            ST_HWAIT: begin
                if (div_done) begin
                    hour_avg_next = div_quotient[SAMPLE_W-1:0];
                    state_next    = ST_OSTART;
                end
            end

            ST_OSTART: begin
                state_next = ST_OWAIT;
            end

            ST_OWAIT: begin
                if (div_done) begin
                    overall_next = div_quotient[SAMPLE_W-1:0];
                    state_next   = (item_reg.minute == LAST_MINUTE) ? ST_DROP : ST_SHOW;
                end
            end

            ST_DROP: begin
                // The read of the oldest entry is issued here and used in
                // the next cycle; once there is room the hour is committed.
                if (hour_count_reg >= eff_hours) begin
                    state_next = ST_DROPSUB;
                end else begin
                    win_we            = 1'b1;
                    hour_sum_next     = hour_sum_reg
                                      + {{(SUM_W-SAMPLE_W){hour_avg_reg[SAMPLE_W-1]}},
                                         hour_avg_reg};
                    hour_count_next   = hour_count_reg + 1'b1;
                    minute_count_next = '0;
                    minute_sum_next   = '0;
                    state_next        = ST_SHOW;
                end
            end

            ST_DROPSUB: begin
                hour_sum_next   = hour_sum_reg
                                - {{(SUM_W-SAMPLE_W){win_rdata[SAMPLE_W-1]}}, win_rdata};
                hour_head_next  = (hour_head_reg == HI_W'(HOUR_SLOTS - 1))
                                ? '0 : hour_head_reg + 1'b1;
                hour_count_next = hour_count_reg - 1'b1;
                state_next      = ST_DROP;
            end

            ST_SHOW: begin
                case (cfg.result_kind)
                    KIND_UNSIGNED: begin
                        if (overall_reg[SAMPLE_W-1]) begin
                            res_next = '{status: STATUS_ERROR, average: '0};
                        end else begin
                            shown_cand = trunc_val;
                            cand_ok    = 1'b1;
                        end
                    end
                    KIND_FIXED: begin
                        shown_cand = overall_reg;
                        cand_ok    = 1'b1;
                    end
                    KIND_SIGNED: begin
                        shown_cand = trunc_val;
                        cand_ok    = 1'b1;
                    end
                    default: begin
                        res_next = '{status: STATUS_NO_CHANGE, average: shown_value_reg};
                    end
                endcase
                if (cand_ok) begin
                    if (shown_cand != shown_value_reg) begin
                        shown_value_next = shown_cand;
                        res_next = '{status: STATUS_NEW_VALUE, average: shown_cand};
                    end else begin
                        res_next = '{status: STATUS_NO_CHANGE, average: shown_value_reg};
                    end
                end
                state_next = ST_OUT;
            end

            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            seen_minute_reg  <= '0;
            minute_count_reg <= '0;
            minute_sum_reg   <= '0;
            hour_count_reg   <= '0;
            hour_head_reg    <= '0;
            hour_sum_reg     <= '0;
            shown_value_reg  <= '0;
        end else begin
            state_reg        <= state_next;
            seen_minute_reg  <= seen_minute_next;
            minute_count_reg <= minute_count_next;
            minute_sum_reg   <= minute_sum_next;
            hour_count_reg   <= hour_count_next;
            hour_head_reg    <= hour_head_next;
            hour_sum_reg     <= hour_sum_next;
            shown_value_reg  <= shown_value_next;
        end
    end

    // Word payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_word;
        end
        hour_avg_reg <= hour_avg_next;
        overall_reg  <= overall_next;
        res_reg      <= res_next;
        if (out_load) begin
            m_word_reg <= res_reg;
        end
    end

    // Output register: a finished word waits here for the consumer while
    // the sequencer returns to idle and takes the next input word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_HWAIT || state_reg == ST_OWAIT))
        else $error("divider finished outside a wait step");

    // The divider is never restarted while still working.
    a_div_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // The window never holds more hours than it has slots.
    a_hour_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hour_count_reg <= HC_W'(HOUR_SLOTS))
        else $error("hour count beyond window depth");

    // The minute count never passes the number of minute slots.
    a_minute_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        minute_count_reg <= MC_W'(MINUTE_SLOTS))
        else $error("minute count beyond slot count");

endmodule

FILE: hw/rtl/hra_div.sv
// ----------------------------------------------------------------------------
// hra_div: iterative signed divider
// Divides a signed dividend by a positive divisor, two quotient bits a cycle,
// and truncates toward zero.
// ----------------------------------------------------------------------------
module hra_div #(
    parameter int DIVIDEND_W = 57,
    parameter int DIVISOR_W  = 9
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]         divisor,
    output logic                         busy,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int STEPS = (DIVIDEND_W + 1) / 2;
    localparam int PAD_W = 2 * STEPS;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [PAD_W-1:0]      mag_reg, mag_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  div_reg;
    logic                  neg_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVIDEND_W-1:0] abs_val;
    logic [DIVISOR_W:0]    part1, part2, diff1, diff2;
    logic [DIVISOR_W-1:0]  rem1;
    logic                  q1, q2;
    logic [DIVIDEND_W-1:0] q_mag;

    always_comb begin
        abs_val = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(~dividend + 1'b1) : dividend;

        // Two restoring steps per cycle on a narrow partial remainder.
        part1    = {rem_reg, mag_reg[PAD_W-1]};
        diff1    = part1 - {1'b0, div_reg};
        q1       = (part1 >= {1'b0, div_reg});
        rem1     = q1 ? diff1[DIVISOR_W-1:0] : part1[DIVISOR_W-1:0];
        part2    = {rem1, mag_reg[PAD_W-2]};
        diff2    = part2 - {1'b0, div_reg};
        q2       = (part2 >= {1'b0, div_reg});
        rem_next = q2 ? diff2[DIVISOR_W-1:0] : part2[DIVISOR_W-1:0];
        mag_next = {mag_reg[PAD_W-3:0], q1, q2};

        q_mag    = mag_reg[DIVIDEND_W-1:0];
        quotient = neg_reg ? DIVIDEND_W'(~q_mag + 1'b1) : q_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                mag_reg  <= PAD_W'(abs_val);
                rem_reg  <= '0;
                div_reg  <= divisor;
                neg_reg  <= dividend[DIVIDEND_W-1];
                cnt_reg  <= CNT_W'(STEPS);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                mag_reg <= mag_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: hw/rtl/hra_window.sv
// ----------------------------------------------------------------------------
// hra_window: storage for committed hourly averages
// Single write port and one registered read port.
// ----------------------------------------------------------------------------
module hra_window #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                                aclk,
    input  logic                                wr_en,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [hra_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]                   rd_addr,
    output logic signed [hra_pkg::SAMPLE_W-1:0] rd_data
);
    import hra_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/hra_regs.sv
// ----------------------------------------------------------------------------
// hra_regs: configuration register file
// APB-style slave holding the window length and the two encodings.
// ----------------------------------------------------------------------------
module hra_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [hra_pkg::ADDR_W-1:0]   paddr,
    input  logic [hra_pkg::DATA_W-1:0]   pwdata,
    output logic [hra_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output hra_pkg::cfg_t                cfg
);
    import hra_pkg::*;

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.avg_hours   <= AVG_HOURS_RESET;
            cfg_reg.source_kind <= KIND_FIXED;
            cfg_reg.result_kind <= KIND_FIXED;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_AVG_HOURS:   cfg_reg.avg_hours   <= pwdata[AVG_HOURS_W-1:0];
                REG_SOURCE_KIND: cfg_reg.source_kind <= pwdata[KIND_W-1:0];
                REG_RESULT_KIND: cfg_reg.result_kind <= pwdata[KIND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_AVG_HOURS:   prdata = DATA_W'(cfg_reg.avg_hours);
            REG_SOURCE_KIND: prdata = DATA_W'(cfg_reg.source_kind);
            REG_RESULT_KIND: prdata = DATA_W'(cfg_reg.result_kind);
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
